// ===== design/relay_override_controller_defines.svh =====
// Assertion macros for the relay override controller checker.
// Used by roc_checker.sv; expects clk and rst in the including scope.
`ifndef RELAY_OVERRIDE_CONTROLLER_DEFINES_SVH
`define RELAY_OVERRIDE_CONTROLLER_DEFINES_SVH

// same-cycle implication, off while in reset
`define ROC_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("roc check failed");

// next-cycle implication, off while in reset
`define ROC_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("roc check failed");

// state right after a reset cycle
`define ROC_CHECK_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("roc reset check failed");

`endif

// ===== design/roc_pkg.sv =====
// Shared types and constants of the relay override controller.
// No dependencies.
package roc_pkg;

  localparam int DEBOUNCE_W = 16;
  localparam int OVERRIDE_W = 22;
  localparam int LOCKOUT_W  = 16;
  localparam int CFG_W      = 22;
  localparam int NUM_RELAYS = 3;
  localparam int NUM_SLOTS  = 4;
  localparam int QDEPTH     = 2;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_AUTO   = 2'd1,
    CMD_MANUAL = 2'd2,
    CMD_MODE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OPM_MANUAL = 2'd0,
    OPM_AUTO   = 2'd1,
    OPM_SCHED  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_AUTO   = 2'd0,
    CAUSE_BUTTON = 2'd1,
    CAUSE_MANUAL = 2'd2
  } cause_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_OVERRIDE = 2'd1,
    REG_LOCKOUT  = 2'd2,
    REG_POLARITY = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] DEV_FAN   = 2'd0;
  localparam logic [1:0] DEV_LIGHT = 2'd1;
  localparam logic [1:0] DEV_PUMP  = 2'd2;
  localparam logic [1:0] DEV_MODE  = 2'd3;

  localparam logic [1:0] TARGET_NONE = 2'd3;
  localparam logic [1:0] MODE_CODE_NONE = 2'd3;

  // one result; its device code is the slot number
  typedef struct packed {
    logic                  state;
    logic [NUM_RELAYS-1:0] levels;
    mode_t                 mode;
  } slot_t;

  // all results of one transaction, slot i fires when mask[i] is set
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    cause_t               cause;
    slot_t [NUM_SLOTS-1:0] slots;
  } group_t;

endpackage

// ===== design/relay_override_controller.sv =====
// Relay override controller: front end, group queue and result serializer.
// Depends on roc_pkg, roc_front, roc_queue and roc_back.
//
// A transaction is decoded and applied to the controller state in the cycle it
// is accepted, so one input transaction can be taken every cycle. Its results
// (up to four) are parked as one group in a two-entry queue and leave the
// output port one per cycle while event_stall is low; the input stalls only
// while both queue entries are occupied. The first result is valid once its
// group has passed through a queue entry and been loaded into the back-end
// group register.
module relay_override_controller #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [roc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      cmd,
  input  logic [3:0]                      button_levels,
  input  logic                            auto_fan,
  input  logic                            auto_light,
  input  logic                            auto_pump,
  input  logic [1:0]                      target,
  input  logic                            turn_on,
  input  logic [1:0]                      new_mode,
  output logic                            event_valid,
  input  logic                            event_stall,
  output logic [1:0]                      device,
  output logic                            device_state,
  output logic [1:0]                      cause,
  output logic [roc_pkg::NUM_RELAYS-1:0]  relay_levels,
  output logic [1:0]                      op_mode,
  output logic                            last
);

  logic            q_full;
  logic            push;
  logic            pop;
  logic            head_valid;
  roc_pkg::group_t push_group;
  roc_pkg::group_t head_group;

  assign item_stall = q_full;

  roc_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (item_valid && !q_full),
    .cmd          (cmd),
    .button_levels(button_levels),
    .auto_fan     (auto_fan),
    .auto_light   (auto_light),
    .auto_pump    (auto_pump),
    .target       (target),
    .turn_on      (turn_on),
    .new_mode     (new_mode),
    .push         (push),
    .group        (push_group)
  );

  roc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_group(push_group),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_group(head_group)
  );

  roc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_group  (head_group),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .device      (device),
    .device_state(device_state),
    .cause       (cause),
    .relay_levels(relay_levels),
    .op_mode     (op_mode),
    .last        (last)
  );

endmodule

// ===== design/roc_front.sv =====
// Front end: configuration registers, controller state and command decode.
// Builds one result group per transaction. Depends on roc_pkg.
module roc_front #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [1:0]                    cfg_index,
  input  logic [roc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  logic [1:0]                    cmd,
  input  logic [3:0]                    button_levels,
  input  logic                          auto_fan,
  input  logic                          auto_light,
  input  logic                          auto_pump,
  input  logic [1:0]                    target,
  input  logic                          turn_on,
  input  logic [1:0]                    new_mode,
  output logic                          push,
  output roc_pkg::group_t               group
);

  localparam int SUM_W = (TIME_BITS > roc_pkg::OVERRIDE_W) ? TIME_BITS : roc_pkg::OVERRIDE_W;
  localparam int NR = roc_pkg::NUM_RELAYS;
  localparam int NS = roc_pkg::NUM_SLOTS;

  logic [roc_pkg::DEBOUNCE_W-1:0] debounce_ticks;
  logic [roc_pkg::OVERRIDE_W-1:0] override_ticks;
  logic [roc_pkg::LOCKOUT_W-1:0]  lockout_ticks;
  logic                           on_high;

  logic [TIME_BITS-1:0] time_now, time_now_next;
  logic [TIME_BITS-1:0] lock_start, lock_start_next;
  logic [TIME_BITS-1:0] override_end [NR];
  logic [TIME_BITS-1:0] override_end_next [NR];
  logic [TIME_BITS-1:0] press_start [NS];
  logic [TIME_BITS-1:0] press_start_next [NS];
  logic [NS-1:0]        press_timing, press_timing_next;
  logic [NS-1:0]        press_done, press_done_next;
  logic [NR-1:0]        relay_on, relay_next;
  roc_pkg::mode_t       mode_reg, mode_next;

  logic [TIME_BITS-1:0] tn;
  logic [SUM_W-1:0]     ovr_sum_tick, ovr_sum_now;
  logic                 locked;
  logic [NS-1:0]        fire;
  logic [NR-1:0]        chg;
  logic                 mode_fire;
  logic [NR-1:0]        want;
  roc_pkg::cause_t      cause;

  assign tn           = time_now + TIME_BITS'(1);
  assign ovr_sum_tick = SUM_W'(tn) + SUM_W'(override_ticks);
  assign ovr_sum_now  = SUM_W'(time_now) + SUM_W'(override_ticks);
  assign locked       = (tn - lock_start) < TIME_BITS'(lockout_ticks);
  assign want         = {auto_pump, auto_light, auto_fan};

  always_comb begin
    time_now_next     = time_now;
    lock_start_next   = lock_start;
    override_end_next = override_end;
    press_start_next  = press_start;
    press_timing_next = press_timing;
    press_done_next   = press_done;
    mode_next         = mode_reg;
    fire              = '0;
    chg               = '0;
    mode_fire         = 1'b0;
    cause             = roc_pkg::CAUSE_AUTO;
    case (cmd)
      roc_pkg::CMD_TICK: begin
        cause         = roc_pkg::CAUSE_BUTTON;
        time_now_next = tn;
        if (locked) begin
          for (int i = 0; i < NS; i++) begin
            press_start_next[i] = '0;
          end
          press_timing_next = '0;
          press_done_next   = '0;
        end else begin
          for (int i = 0; i < NS; i++) begin
            if (!button_levels[i]) begin
              if (!press_timing[i]) begin
                press_timing_next[i] = 1'b1;
                press_start_next[i]  = tn;
              end else if (!press_done[i] &&
                           (tn - press_start[i]) >= TIME_BITS'(debounce_ticks)) begin
                press_done_next[i] = 1'b1;
                fire[i]            = 1'b1;
              end
            end else begin
              press_start_next[i]  = '0;
              press_timing_next[i] = 1'b0;
              press_done_next[i]   = 1'b0;
            end
          end
          chg       = fire[NR-1:0];
          mode_fire = fire[NR];
          for (int i = 0; i < NR; i++) begin
            if (chg[i]) begin
              override_end_next[i] = (mode_reg == roc_pkg::OPM_AUTO) ?
                                     ovr_sum_tick[TIME_BITS-1:0] : '0;
            end
          end
          if (|chg) begin
            lock_start_next = tn;
          end
          if (mode_fire) begin
            mode_next = (mode_reg == roc_pkg::OPM_SCHED) ? roc_pkg::OPM_MANUAL :
                        roc_pkg::mode_t'(mode_reg + 2'd1);
            if (mode_next != roc_pkg::OPM_MANUAL) begin
              for (int i = 0; i < NR; i++) begin
                override_end_next[i] = '0;
              end
            end
          end
        end
      end
      roc_pkg::CMD_AUTO: begin
        cause = roc_pkg::CAUSE_AUTO;
        if (mode_reg == roc_pkg::OPM_AUTO) begin
          for (int i = 0; i < NR; i++) begin
            chg[i] = (time_now >= override_end[i]) && (relay_on[i] != want[i]);
          end
          if (|chg) begin
            lock_start_next = time_now;
          end
        end
      end
      roc_pkg::CMD_MANUAL: begin
        cause = roc_pkg::CAUSE_MANUAL;
        if (target != roc_pkg::TARGET_NONE) begin
          override_end_next[target] = (mode_reg == roc_pkg::OPM_AUTO) ?
                                      ovr_sum_now[TIME_BITS-1:0] : '0;
          if (relay_on[target] != turn_on) begin
            chg[target]     = 1'b1;
            lock_start_next = time_now;
          end
        end
      end
      roc_pkg::CMD_MODE: begin
        cause = roc_pkg::CAUSE_MANUAL;
        if (new_mode != roc_pkg::MODE_CODE_NONE) begin
          mode_next = roc_pkg::mode_t'(new_mode);
          if (mode_next != roc_pkg::OPM_MANUAL) begin
            for (int i = 0; i < NR; i++) begin
              override_end_next[i] = '0;
            end
          end
        end
      end
      default: begin
        cause = roc_pkg::CAUSE_AUTO;
      end
    endcase
  end

  assign relay_next = relay_on ^ chg;

  // slot i sees relays up to i already switched
  always_comb begin
    logic [NR-1:0] b;
    logic [NS-1:0] st;
    st          = {1'b0, relay_next};
    group.mask  = {mode_fire, chg};
    group.cause = cause;
    for (int i = 0; i < NS; i++) begin
      for (int j = 0; j < NR; j++) begin
        b[j] = (j <= i) ? relay_next[j] : relay_on[j];
      end
      group.slots[i].state  = st[i];
      group.slots[i].levels = on_high ? b : ~b;
      group.slots[i].mode   = (i < NR) ? mode_reg : mode_next;
    end
  end

  assign push = accept && (|group.mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= roc_pkg::DEBOUNCE_W'(50);
      override_ticks <= roc_pkg::OVERRIDE_W'(300000);
      lockout_ticks  <= roc_pkg::LOCKOUT_W'(1000);
      on_high        <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        roc_pkg::REG_DEBOUNCE: debounce_ticks <= cfg_data[roc_pkg::DEBOUNCE_W-1:0];
        roc_pkg::REG_OVERRIDE: override_ticks <= cfg_data[roc_pkg::OVERRIDE_W-1:0];
        roc_pkg::REG_LOCKOUT:  lockout_ticks  <= cfg_data[roc_pkg::LOCKOUT_W-1:0];
        roc_pkg::REG_POLARITY: on_high        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now     <= '0;
      lock_start   <= '0;
      press_timing <= '0;
      press_done   <= '0;
      relay_on     <= '0;
      mode_reg     <= roc_pkg::OPM_AUTO;
      for (int i = 0; i < NR; i++) begin
        override_end[i] <= '0;
      end
      for (int i = 0; i < NS; i++) begin
        press_start[i] <= '0;
      end
    end else if (accept) begin
      time_now     <= time_now_next;
      lock_start   <= lock_start_next;
      press_timing <= press_timing_next;
      press_done   <= press_done_next;
      relay_on     <= relay_next;
      mode_reg     <= mode_next;
      override_end <= override_end_next;
      press_start  <= press_start_next;
    end
  end

endmodule

// ===== design/roc_queue.sv =====
// Short queue of result groups between front and back end.
// Depends on roc_pkg.
module roc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  roc_pkg::group_t push_group,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output roc_pkg::group_t head_group
);

  localparam int PTR_W = $clog2(roc_pkg::QDEPTH);
  localparam int CNT_W = $clog2(roc_pkg::QDEPTH + 1);

  roc_pkg::group_t entries [roc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = count == CNT_W'(roc_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head_group = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/roc_back.sv =====
// Back end: takes result groups from the queue and sends one result per
// cycle from a registered group unless stalled. Depends on roc_pkg.
module roc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  roc_pkg::group_t                 head_group,
  output logic                            pop,
  output logic                            event_valid,
  input  logic                            event_stall,
  output logic [1:0]                      device,
  output logic                            device_state,
  output logic [1:0]                      cause,
  output logic [roc_pkg::NUM_RELAYS-1:0]  relay_levels,
  output logic [1:0]                      op_mode,
  output logic                            last
);

  localparam int NS    = roc_pkg::NUM_SLOTS;
  localparam int IDX_W = $clog2(NS);

  roc_pkg::group_t grp;
  logic [NS-1:0]   mask;
  logic [NS-1:0]   rem, mask_after;
  logic [IDX_W-1:0] idx;
  logic            accept;

  always_comb begin
    idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign rem          = mask & ~(NS'(1) << idx);
  assign event_valid  = |mask;
  assign accept       = event_valid && !event_stall;
  assign mask_after   = accept ? rem : mask;
  assign pop          = head_valid && (mask_after == '0);

  assign device       = idx;
  assign device_state = grp.slots[idx].state;
  assign cause        = grp.cause;
  assign relay_levels = grp.slots[idx].levels;
  assign op_mode      = grp.slots[idx].mode;
  assign last         = rem == '0;

  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= head_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (pop) begin
      mask <= head_group.mask;
    end else begin
      mask <= mask_after;
    end
  end

endmodule

// ===== design/roc_checker.sv =====
// Port-level checks for relay_override_controller, attached by bind.
// Depends on relay_override_controller_defines.svh and roc_pkg.
`include "relay_override_controller_defines.svh"

module roc_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_stall,
  input logic       event_valid,
  input logic       event_stall,
  input logic [1:0] device,
  input logic       device_state,
  input logic [1:0] cause,
  input logic [2:0] relay_levels,
  input logic [1:0] op_mode,
  input logic       last
);

  `ROC_CHECK_NEXT(a_hold, event_valid && event_stall, event_valid && $stable(device) && $stable(device_state) && $stable(relay_levels) && $stable(op_mode) && $stable(last))
  `ROC_CHECK_NEXT(a_more, event_valid && !event_stall && !last, event_valid)
  `ROC_CHECK_NOW(a_mode_evt, event_valid && device == roc_pkg::DEV_MODE, !device_state && cause == roc_pkg::CAUSE_BUTTON)
  `ROC_CHECK_RST(a_rst_out, !event_valid)
  `ROC_CHECK_RST(a_rst_in, !item_stall)

endmodule

bind relay_override_controller roc_checker u_chk (.*);
